// ===== rtl/core/pfdc_pkg.sv =====
`default_nettype none
package pfdc_pkg;

  localparam int GRID_SIDE   = 5;
  localparam int CELLS       = GRID_SIDE * GRID_SIDE;
  localparam int NUM_LETTERS = 26;
  localparam int IDX_W       = $clog2(GRID_SIDE);
  localparam int CELL_W      = $clog2(CELLS);

  typedef logic [4:0]        letter_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam letter_t LETTER_A = 5'd0;
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;

  // request codes
  localparam logic [2:0] REQ_CLEAR    = 3'd0;
  localparam logic [2:0] REQ_KEY      = 3'd1;
  localparam logic [2:0] REQ_COMPLETE = 3'd2;
  localparam logic [2:0] REQ_ENCRYPT  = 3'd3;
  localparam logic [2:0] REQ_DECRYPT  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_LOOK1,
    S_LOOK2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0] req;
    letter_t    a;
    letter_t    b;
  } item_t;

  typedef struct packed {
    logic       valid;
    letter_t    a;
    letter_t    b;
    logic [1:0] status;
  } result_t;

  // one write and two reads per cycle; both stores use 5-bit address and data
  typedef struct packed {
    logic    we;
    cell_t   waddr;
    letter_t wdata;
    cell_t   raddr0;
    cell_t   raddr1;
  } ram_port_t;

  function automatic letter_t clamp_letter(input letter_t v);
    return (v > LETTER_Z) ? LETTER_Z : v;
  endfunction

  function automatic letter_t fold_j(input letter_t v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

  function automatic idx_t cell_row(input cell_t p);
    idx_t r;
    r = '0;
    for (int i = 1; i < GRID_SIDE; i++) begin
      if (p >= CELL_W'(i * GRID_SIDE)) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic idx_t cell_col(input cell_t p, input idx_t r);
    return IDX_W'(p - CELL_W'(r) * CELL_W'(GRID_SIDE));
  endfunction

  function automatic cell_t cell_of(input idx_t r, input idx_t c);
    return CELL_W'(r) * CELL_W'(GRID_SIDE) + CELL_W'(c);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pfdc_ram.sv =====
`default_nettype none
module pfdc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output      logic [WIDTH-1:0]         rdata0,
  output      logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

// ===== rtl/core/pfdc_geom.sv =====
`default_nettype none
module pfdc_geom (
  input  wire pfdc_pkg::cell_t pos_a,
  input  wire pfdc_pkg::cell_t pos_b,
  input  wire logic            decrypt,
  output      pfdc_pkg::cell_t cell_a,
  output      pfdc_pkg::cell_t cell_b
);

  pfdc_pkg::idx_t r1, c1, r2, c2;
  pfdc_pkg::idx_t nr1, nc1, nr2, nc2;

  function automatic pfdc_pkg::idx_t wrap_step(input pfdc_pkg::idx_t v, input logic back);
    localparam pfdc_pkg::idx_t LAST = pfdc_pkg::IDX_W'(pfdc_pkg::GRID_SIDE - 1);
    pfdc_pkg::idx_t n;
    if (back) n = (v == '0) ? LAST : v - 1'b1;
    else      n = (v == LAST) ? '0 : v + 1'b1;
    return n;
  endfunction

  always_comb begin
    r1 = pfdc_pkg::cell_row(pos_a);
    r2 = pfdc_pkg::cell_row(pos_b);
    c1 = pfdc_pkg::cell_col(pos_a, r1);
    c2 = pfdc_pkg::cell_col(pos_b, r2);
    nr1 = r1;
    nr2 = r2;
    nc1 = c1;
    nc2 = c2;
    priority if (r1 == r2) begin
      nc1 = wrap_step(c1, decrypt);
      nc2 = wrap_step(c2, decrypt);
    end else if (c1 == c2) begin
      nr1 = wrap_step(r1, decrypt);
      nr2 = wrap_step(r2, decrypt);
    end else begin
      nc1 = c2;
      nc2 = c1;
    end
    cell_a = pfdc_pkg::cell_of(nr1, nc1);
    cell_b = pfdc_pkg::cell_of(nr2, nc2);
  end

endmodule
`default_nettype wire

// ===== rtl/core/pfdc_engine.sv =====
`default_nettype none
module pfdc_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire pfdc_pkg::item_t      item,
  output      pfdc_pkg::ram_port_t  key_port,
  input  wire pfdc_pkg::letter_t    key_rdata0,
  input  wire pfdc_pkg::letter_t    key_rdata1,
  output      pfdc_pkg::ram_port_t  pos_port,
  input  wire pfdc_pkg::cell_t      pos_rdata0,
  input  wire pfdc_pkg::cell_t      pos_rdata1,
  input  wire logic                 out_free,
  output      pfdc_pkg::result_t    result
);

  pfdc_pkg::state_t  state, state_next;
  logic [2:0]        req;
  pfdc_pkg::letter_t let_a, let_b;
  logic [pfdc_pkg::NUM_LETTERS-1:0] used, used_next;
  pfdc_pkg::cell_t   fill, fill_next;
  logic              ready, ready_next;
  pfdc_pkg::letter_t cnt, cnt_next;
  pfdc_pkg::result_t res, res_next;

  logic              place_en, do_place;
  pfdc_pkg::letter_t place_c;
  pfdc_pkg::cell_t   cell_a, cell_b;
  logic              is_pair, full;

  assign is_pair = (req == pfdc_pkg::REQ_ENCRYPT) || (req == pfdc_pkg::REQ_DECRYPT);
  assign full    = (fill >= pfdc_pkg::CELL_W'(pfdc_pkg::CELLS));

  pfdc_geom u_geom (
    .pos_a   (pos_rdata0),
    .pos_b   (pos_rdata1),
    .decrypt (req == pfdc_pkg::REQ_DECRYPT),
    .cell_a  (cell_a),
    .cell_b  (cell_b)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfdc_pkg::S_IDLE: begin
        if (in_valid) state_next = pfdc_pkg::S_EXEC;
      end
      pfdc_pkg::S_EXEC: begin
        if (req == pfdc_pkg::REQ_COMPLETE) state_next = pfdc_pkg::S_FILL;
        else if (is_pair && ready)         state_next = pfdc_pkg::S_LOOK1;
        else                               state_next = pfdc_pkg::S_EMIT;
      end
      pfdc_pkg::S_FILL: begin
        if (cnt == 5'(pfdc_pkg::NUM_LETTERS - 1)) state_next = pfdc_pkg::S_EMIT;
      end
      pfdc_pkg::S_LOOK1: state_next = pfdc_pkg::S_LOOK2;
      pfdc_pkg::S_LOOK2: state_next = pfdc_pkg::S_EMIT;
      pfdc_pkg::S_EMIT: begin
        if (out_free) state_next = pfdc_pkg::S_IDLE;
      end
      default: state_next = pfdc_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready   = (state == pfdc_pkg::S_IDLE);
    place_en   = 1'b0;
    place_c    = let_a;
    used_next  = used;
    fill_next  = fill;
    ready_next = ready;
    cnt_next   = cnt;
    res_next   = res;
    key_port   = '0;
    pos_port   = '0;

    unique case (state)
      pfdc_pkg::S_IDLE: begin
      end
      pfdc_pkg::S_EXEC: begin
        res_next = '0;
        cnt_next = '0;
        unique case (req)
          pfdc_pkg::REQ_CLEAR: begin
            used_next  = '0;
            fill_next  = '0;
            ready_next = 1'b0;
          end
          pfdc_pkg::REQ_KEY: begin
            if (full) res_next.status = pfdc_pkg::ST_FULL;
            else      place_en = 1'b1;
          end
          pfdc_pkg::REQ_ENCRYPT, pfdc_pkg::REQ_DECRYPT: begin
            if (!ready) res_next.status = pfdc_pkg::ST_NOT_READY;
            pos_port.raddr0 = pfdc_pkg::fold_j(let_a);
            pos_port.raddr1 = pfdc_pkg::fold_j(let_b);
          end
          default: begin
          end
        endcase
      end
      pfdc_pkg::S_FILL: begin
        place_en = 1'b1;
        place_c  = cnt;
        cnt_next = cnt + 1'b1;
        if (cnt == 5'(pfdc_pkg::NUM_LETTERS - 1)) ready_next = 1'b1;
      end
      pfdc_pkg::S_LOOK1: begin
        key_port.raddr0 = cell_a;
        key_port.raddr1 = cell_b;
      end
      pfdc_pkg::S_LOOK2: begin
        res_next.a = key_rdata0;
        res_next.b = key_rdata1;
      end
      pfdc_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase

    // J, duplicates and a full square drop the letter
    do_place = place_en && (place_c != pfdc_pkg::LETTER_J) && !full && !used[place_c];
    if (do_place) begin
      used_next[place_c] = 1'b1;
      fill_next          = fill + 1'b1;
      key_port.we        = 1'b1;
      key_port.waddr     = fill;
      key_port.wdata     = place_c;
      pos_port.we        = 1'b1;
      pos_port.waddr     = place_c;
      pos_port.wdata     = fill;
    end

    result       = res;
    result.valid = (state == pfdc_pkg::S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfdc_pkg::S_IDLE;
      used  <= '0;
      fill  <= '0;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      fill  <= fill_next;
      ready <= ready_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    res <= res_next;
    if (in_valid && in_ready) begin
      req   <= item.req;
      let_a <= pfdc_pkg::clamp_letter(item.a);
      let_b <= pfdc_pkg::clamp_letter(item.b);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/playfair_digraph_cipher.sv =====
`default_nettype none
// Channel   Dir  Fields (tdata, lowest bit up)
// s_*       in   req_type[2:0], letter_a[7:3], letter_b[12:8], zero pad [15:13]
// m_*       out  out_a[4:0], out_b[9:5], status[11:10], zero pad [15:12]
//
// One item at a time. Clear, key letter and unknown requests go from input
// transfer through the execute step to the emit step; encrypt/decrypt add
// a position read, then a square read, each a registered memory port; complete
// adds a fill step, one letter per cycle through the single write port of each store.
// Reset (synchronous) empties the square; the stores themselves are not
// cleared, and the cell -> letter store is only read once the square has been completed.
// The result register lets the next item start while a result waits;
// the engine holds in its emit step while that register is still full.
module playfair_digraph_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // req_type, letter_a, letter_b
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata    // out_a, out_b, status
);

  pfdc_pkg::item_t     item;
  pfdc_pkg::ram_port_t key_port, pos_port;
  pfdc_pkg::letter_t   key_rdata0, key_rdata1;
  pfdc_pkg::cell_t     pos_rdata0, pos_rdata1;
  pfdc_pkg::result_t   eng_res;
  logic                out_free, out_load;

  assign item.req = s_tdata[2:0];
  assign item.a   = s_tdata[7:3];
  assign item.b   = s_tdata[12:8];

  assign out_free = !m_tvalid || m_tready;
  assign out_load = eng_res.valid && out_free;

  pfdc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item       (item),
    .key_port   (key_port),
    .key_rdata0 (key_rdata0),
    .key_rdata1 (key_rdata1),
    .pos_port   (pos_port),
    .pos_rdata0 (pos_rdata0),
    .pos_rdata1 (pos_rdata1),
    .out_free   (out_free),
    .result     (eng_res)
  );

  // cell -> letter
  pfdc_ram #(.WIDTH(5), .DEPTH(pfdc_pkg::CELLS)) u_key_ram (
    .clk    (clk),
    .we     (key_port.we),
    .waddr  (key_port.waddr),
    .wdata  (key_port.wdata),
    .raddr0 (key_port.raddr0),
    .raddr1 (key_port.raddr1),
    .rdata0 (key_rdata0),
    .rdata1 (key_rdata1)
  );

  // letter -> cell
  pfdc_ram #(.WIDTH(pfdc_pkg::CELL_W), .DEPTH(pfdc_pkg::NUM_LETTERS)) u_pos_ram (
    .clk    (clk),
    .we     (pos_port.we),
    .waddr  (pos_port.waddr),
    .wdata  (pos_port.wdata),
    .raddr0 (pos_port.raddr0),
    .raddr1 (pos_port.raddr1),
    .rdata0 (pos_rdata0),
    .rdata1 (pos_rdata1)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {4'b0, eng_res.status, eng_res.b, eng_res.a};
  end

  // a loaded result is presented on the next cycle
  assert property (@(posedge clk) disable iff (rst) out_load |=> m_tvalid)
    else $error("result load lost");

  // no new transfer while the engine still holds an undelivered result
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |-> !eng_res.valid)
    else $error("input taken during emit");

  // error status carries no letters
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tdata[11:10] != pfdc_pkg::ST_OK) |-> (m_tdata[9:0] == 10'd0))
    else $error("letters on error status");

  // result letters stay in the alphabet
  assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[4:0] <= pfdc_pkg::LETTER_Z && m_tdata[9:5] <= pfdc_pkg::LETTER_Z))
    else $error("result letter out of range");

endmodule
`default_nettype wire
